// File: hw/rtl/bpa_pkg.sv
`default_nettype none

package bpa_pkg;

   // sequencer states
   typedef enum logic [2:0] {
      ST_SETUP,
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_REL,
      ST_RESULT
   } state_type;

   // command codes
   localparam logic CMD_ALLOC   = 1'b0;
   localparam logic CMD_RELEASE = 1'b1;

   // result status codes
   localparam logic [1:0] STAT_DONE         = 2'd0;
   localparam logic [1:0] STAT_NO_MEMORY    = 2'd1;
   localparam logic [1:0] STAT_RANGE        = 2'd2;
   localparam logic [1:0] STAT_ALREADY_FREE = 2'd3;

   // register indexes (word address bit 2)
   localparam logic REG_KERNEL_END = 1'b0;
   localparam logic REG_MEMORY_END = 1'b1;

   // register reset values
   localparam logic [31:0] KERNEL_END_RST = 32'h0000_0000;
   localparam logic [31:0] MEMORY_END_RST = 32'h0800_0000;

   // managed range limits
   localparam logic [31:0] LOW_LIMIT = 32'h0020_0000;
   localparam logic [31:0] END_LIMIT = 32'hFFFF_FF00;

   // index of the lowest set bit, binary search in five steps
   function automatic logic [4:0] low_bit(input logic [31:0] w);
      logic [31:0] v;
      logic [4:0]  r;
      v = w;
      r = '0;
      if (v[15:0] == 16'd0) begin
         r[4] = 1'b1;
         v    = v >> 16;
      end
      if (v[7:0] == 8'd0) begin
         r[3] = 1'b1;
         v    = v >> 8;
      end
      if (v[3:0] == 4'd0) begin
         r[2] = 1'b1;
         v    = v >> 4;
      end
      if (v[1:0] == 2'd0) begin
         r[1] = 1'b1;
         v    = v >> 2;
      end
      if (v[0] == 1'b0) begin
         r[0] = 1'b1;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/bpa_geom.sv
`default_nettype none

module bpa_geom #(
   parameter int MAX_PAGES  = 32768,
   parameter int PAGE_BYTES = 4096
) (
   input  logic [31:0]                      kend_addr,
   input  logic [31:0]                      mend_addr,
   output logic [31:0]                      first_page,
   output logic [$clog2(MAX_PAGES+1)-1:0]   page_total
);
   import bpa_pkg::*;

   localparam int PG_SH = $clog2(PAGE_BYTES);
   localparam int PG_W  = 33 - PG_SH;
   localparam int EP_W  = 32 - PG_SH;
   localparam int CNT_W = $clog2(MAX_PAGES + 1);

   logic [32:0]     start_rnd;
   logic [PG_W-1:0] start_pg;
   logic [PG_W-1:0] low_pg;
   logic [PG_W-1:0] eff_pg;
   logic [31:0]     end_clip;
   logic [EP_W-1:0] end_pg;
   logic [PG_W-1:0] span;
   logic            cap;

   // start page: round up, then raise to the low limit
   always_comb begin
      start_rnd = {1'b0, kend_addr} + 33'(PAGE_BYTES - 1);
      start_pg  = start_rnd[32:PG_SH];
      low_pg    = PG_W'(LOW_LIMIT >> PG_SH);
      eff_pg    = (start_pg < low_pg) ? low_pg : start_pg;
   end

   // end page and page span, capped at the map size
   always_comb begin
      end_clip   = (mend_addr > END_LIMIT) ? END_LIMIT : mend_addr;
      end_pg     = end_clip[31:PG_SH];
      span       = (PG_W'(end_pg) > eff_pg) ? (PG_W'(end_pg) - eff_pg) : '0;
      cap        = 33'(span) > 33'(MAX_PAGES);
      page_total = cap ? CNT_W'(MAX_PAGES) : CNT_W'(span);
      first_page = 32'(eff_pg);
   end

endmodule

`default_nettype wire

// File: hw/rtl/bitmap_page_allocator_core.sv
// steps: out of memory and out-of-range release go from idle straight to the result state;
//   release reads the map word, then updates it; allocate scans words from the lowest-free hint
// throughput: one item at a time, limited by the word-by-word scan of the free map;
//   the next item is taken once the previous result has moved to the output register
// reset and every register write run a setup step and a clearing pass over every map word,
//   during which no item is accepted
`default_nettype none

module bitmap_page_allocator_core #(
   parameter int MAX_PAGES  = 32768,
   parameter int PAGE_BYTES = 4096
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_cmd,
   input  logic [31:0] req_release_address,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_granted_address,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_free_pages,
   output logic [15:0] rsp_managed_pages,
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import bpa_pkg::*;

   localparam int PG_SH     = $clog2(PAGE_BYTES);
   localparam int CNT_W     = $clog2(MAX_PAGES + 1);
   localparam int MAP_WORDS = (MAX_PAGES + 31) / 32;
   localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int IDX_W     = AW + 5;

   // registers
   state_type        state_ff, state_in;
   logic [31:0]      kend_ff, mend_ff;
   logic [31:0]      first_page_ff, first_page_in;
   logic [CNT_W-1:0] page_total_ff, page_total_in;
   logic [CNT_W-1:0] free_total_ff, free_total_in;
   logic [AW-1:0]    hint_ff, hint_in;
   logic [AW-1:0]    scan_ff, scan_in;
   logic [AW-1:0]    clr_ff, clr_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [31:0]      res_granted_ff, res_granted_in;
   logic [1:0]       res_status_ff, res_status_in;
   logic [CNT_W-1:0] res_free_ff, res_free_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [31:0]      rsp_granted_ff;
   logic [1:0]       rsp_status_ff;
   logic [15:0]      rsp_free_ff;
   logic [15:0]      rsp_managed_ff;

   // free map memory, one bit per page, set = free
   logic [31:0]      map_mem [MAP_WORDS];
   logic [31:0]      rdata_ff;
   logic [AW-1:0]    rd_word_ff;
   logic             mem_we;
   logic [AW-1:0]    mem_waddr;
   logic [31:0]      mem_wdata;
   logic [AW-1:0]    mem_raddr;

   // setup geometry
   logic [31:0]      geo_first;
   logic [CNT_W-1:0] geo_total;

   // helpers
   logic             cfg_wr;
   logic             req_beat;
   logic             rsp_load;
   logic [CNT_W-1:0] full_words;
   logic [31:0]      clr_word;
   logic [32:0]      rel_off;
   logic             rel_in_range;
   logic [4:0]       found_bit;
   logic [IDX_W-1:0] found_idx;
   logic [32:0]      grant_pg;
   logic [31:0]      bit_mask;
   logic [AW-1:0]    idx_word;

   bpa_geom #(
      .MAX_PAGES  (MAX_PAGES),
      .PAGE_BYTES (PAGE_BYTES)
   ) u_geom (
      .kend_addr  (kend_ff),
      .mend_addr  (mend_ff),
      .first_page (geo_first),
      .page_total (geo_total)
   );

   // register port
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_MEMORY_END) ? mend_ff : kend_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         kend_ff <= KERNEL_END_RST;
         mend_ff <= MEMORY_END_RST;
      end else if (cfg_wr) begin
         if (csr_paddr[2] == REG_KERNEL_END) begin
            kend_ff <= csr_pwdata;
         end else begin
            mend_ff <= csr_pwdata;
         end
      end
   end

   // handshakes
   assign req_stall = (state_ff != ST_IDLE);
   assign req_beat  = req_valid && !req_stall;
   assign rsp_load  = (state_ff == ST_RESULT) && (!rsp_valid_ff || !rsp_stall);

   // clearing pass word: full words, one partial word, then zeros
   always_comb begin
      full_words = page_total_ff >> 5;
      if (32'(clr_ff) < 32'(full_words)) begin
         clr_word = '1;
      end else if (32'(clr_ff) == 32'(full_words)) begin
         clr_word = (32'd1 << page_total_ff[4:0]) - 32'd1;
      end else begin
         clr_word = '0;
      end
   end

   // release address to page offset
   always_comb begin
      rel_off      = 33'(req_release_address[31:PG_SH]) - 33'(first_page_ff);
      rel_in_range = !rel_off[32] && (rel_off < 33'(page_total_ff));
   end

   // lowest free page in the word just read
   always_comb begin
      found_bit = low_bit(rdata_ff);
      found_idx = {rd_word_ff, found_bit};
      grant_pg  = 33'(first_page_ff) + 33'(found_idx);
      idx_word  = idx_ff[IDX_W-1:5];
      bit_mask  = 32'd1 << ((state_ff == ST_SCAN) ? found_bit : idx_ff[4:0]);
   end

   // sequencer: next state, memory control, counters
   always_comb begin
      state_in       = state_ff;
      first_page_in  = first_page_ff;
      page_total_in  = page_total_ff;
      free_total_in  = free_total_ff;
      hint_in        = hint_ff;
      scan_in        = scan_ff;
      clr_in         = clr_ff;
      idx_in         = idx_ff;
      res_granted_in = res_granted_ff;
      res_status_in  = res_status_ff;
      res_free_in    = res_free_ff;
      mem_we         = 1'b0;
      mem_waddr      = clr_ff;
      mem_wdata      = clr_word;
      mem_raddr      = scan_ff;

      unique case (state_ff)
         ST_SETUP: begin
            first_page_in = geo_first;
            page_total_in = geo_total;
            free_total_in = geo_total;
            hint_in       = '0;
            clr_in        = '0;
            state_in      = ST_CLEAR;
         end
         ST_CLEAR: begin
            mem_we = 1'b1;
            clr_in = clr_ff + AW'(1);
            if (32'(clr_ff) == 32'(MAP_WORDS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_beat) begin
               res_granted_in = '0;
               res_free_in    = free_total_ff;
               if (req_cmd == CMD_ALLOC) begin
                  if (free_total_ff == '0) begin
                     res_status_in = STAT_NO_MEMORY;
                     state_in      = ST_RESULT;
                  end else begin
                     mem_raddr = hint_ff;
                     scan_in   = hint_ff + AW'(1);
                     state_in  = ST_SCAN;
                  end
               end else begin
                  if (!rel_in_range) begin
                     res_status_in = STAT_RANGE;
                     state_in      = ST_RESULT;
                  end else begin
                     idx_in    = rel_off[IDX_W-1:0];
                     mem_raddr = rel_off[IDX_W-1:5];
                     state_in  = ST_REL;
                  end
               end
            end
         end
         ST_SCAN: begin
            if (rdata_ff != 32'd0) begin
               mem_we         = 1'b1;
               mem_waddr      = rd_word_ff;
               mem_wdata      = rdata_ff & ~bit_mask;
               free_total_in  = free_total_ff - CNT_W'(1);
               res_free_in    = free_total_ff - CNT_W'(1);
               hint_in        = rd_word_ff;
               res_granted_in = 32'(grant_pg << PG_SH);
               res_status_in  = STAT_DONE;
               state_in       = ST_RESULT;
            end else begin
               mem_raddr = scan_ff;
               scan_in   = scan_ff + AW'(1);
            end
         end
         ST_REL: begin
            if ((rdata_ff & bit_mask) != 32'd0) begin
               res_status_in = STAT_ALREADY_FREE;
            end else begin
               mem_we        = 1'b1;
               mem_waddr     = idx_word;
               mem_wdata     = rdata_ff | bit_mask;
               free_total_in = free_total_ff + CNT_W'(1);
               res_free_in   = free_total_ff + CNT_W'(1);
               res_status_in = STAT_DONE;
               if (idx_word < hint_ff) begin
                  hint_in = idx_word;
               end
            end
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_SETUP;
         end
      endcase

      // a register write restarts setup
      if (cfg_wr) begin
         state_in = ST_SETUP;
      end
   end

   // output register valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_SETUP;
         rsp_valid_ff  <= 1'b0;
         first_page_ff <= '0;
         page_total_ff <= '0;
         free_total_ff <= '0;
         hint_ff       <= '0;
         scan_ff       <= '0;
         clr_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         first_page_ff <= first_page_in;
         page_total_ff <= page_total_in;
         free_total_ff <= free_total_in;
         hint_ff       <= hint_in;
         scan_ff       <= scan_in;
         clr_ff        <= clr_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      res_granted_ff <= res_granted_in;
      res_status_ff  <= res_status_in;
      res_free_ff    <= res_free_in;
      if (rsp_load) begin
         rsp_granted_ff <= res_granted_ff;
         rsp_status_ff  <= res_status_ff;
         rsp_free_ff    <= 16'(res_free_ff);
         rsp_managed_ff <= 16'(page_total_ff);
      end
   end

   // free map: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         map_mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff   <= map_mem[mem_raddr];
      rd_word_ff <= mem_raddr;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_granted_address = rsp_granted_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_free_pages      = rsp_free_ff;
   assign rsp_managed_pages   = rsp_managed_ff;

endmodule

`default_nettype wire

// File: hw/rtl/bpa_checker.sv
`default_nettype none

module bpa_checker #(
   parameter int MAX_PAGES = 32768
) (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [31:0] rsp_granted_address,
   input wire logic [1:0]  rsp_status,
   input wire logic [15:0] rsp_free_pages,
   input wire logic [15:0] rsp_managed_pages
);
   import bpa_pkg::*;

   localparam bit COUNTS_FIT = (MAX_PAGES < 65536);

   // a stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_granted_address)
         && $stable(rsp_status) && $stable(rsp_free_pages))
      else $error("stalled response beat changed");

   // one item in flight: busy right after a request beat
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while an item is in flight");

   // only a successful allocate carries an address
   a_no_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STAT_DONE |-> rsp_granted_address == 32'd0)
      else $error("address given with a failing status");

   // out of memory means no free page is left
   a_oom_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STAT_NO_MEMORY |-> rsp_free_pages == 16'd0)
      else $error("out of memory with free pages left");

   // free count never exceeds managed count
   a_free_le: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && COUNTS_FIT |-> rsp_free_pages <= rsp_managed_pages)
      else $error("free count above managed count");

endmodule

bind bitmap_page_allocator_core bpa_checker #(.MAX_PAGES(MAX_PAGES)) u_bpa_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_stall           (req_stall),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_granted_address (rsp_granted_address),
   .rsp_status          (rsp_status),
   .rsp_free_pages      (rsp_free_pages),
   .rsp_managed_pages   (rsp_managed_pages)
);

`default_nettype wire

// File: dv/tb_bitmap_page_allocator_core.sv
`default_nettype none

module tb_bitmap_page_allocator_core;
   import bpa_pkg::*;

   localparam int          MAX_PAGES   = 32768;
   localparam int          PAGE_BYTES  = 4096;
   localparam int          CLK_PERIOD  = 4;
   localparam int          HOLD_CYCLES = 1500;
   localparam int          DRAIN_WAIT  = 40;
   localparam logic [2:0]  ADDR_KERNEL = {REG_KERNEL_END, 2'b00};
   localparam logic [2:0]  ADDR_MEMORY = {REG_MEMORY_END, 2'b00};

   // one result beat
   typedef struct packed {
      logic [31:0] granted;
      logic [1:0]  status;
      logic [15:0] free;
      logic [15:0] managed;
   } page_result_type;

   typedef enum logic {ROW_ITEM, ROW_REG} row_kind_type;

   // one line of the directed plan
   typedef struct packed {
      row_kind_type    kind;
      logic            cmd;
      logic [2:0]      reg_addr;
      logic [31:0]     value;
      logic            typed;
      page_result_type want;
   } plan_row_type;

   // dut signals, all inputs known from time zero
   logic        clock               = 1'b0;
   logic        reset               = 1'b1;
   logic        req_valid           = 1'b0;
   logic        req_stall;
   logic        req_cmd             = CMD_ALLOC;
   logic [31:0] req_release_address = '0;
   logic        rsp_valid;
   logic        rsp_stall           = 1'b0;
   logic [31:0] rsp_granted_address;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_free_pages;
   logic [15:0] rsp_managed_pages;
   logic        csr_psel            = 1'b0;
   logic        csr_penable         = 1'b0;
   logic        csr_pwrite          = 1'b0;
   logic [2:0]  csr_paddr           = '0;
   logic [31:0] csr_pwdata          = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // allocator mirror
   logic [31:0]          shadow_kend;
   logic [31:0]          memory_end;
   bit [MAX_PAGES-1:0]   page_free;
   logic [31:0]          shadow_first;
   int unsigned          managed_count;
   int unsigned          shadow_free;
   logic [31:0]          in_use_pages[$];
   page_result_type      awaited_results[$];

   // traffic shaping
   bit                   quiet_mode   = 1'b0;
   bit                   hold_off_req = 1'b0;
   bit                   holding      = 1'b0;
   int                   errors       = 0;

   plan_row_type         plan[$];

   bitmap_page_allocator_core #(
      .MAX_PAGES (MAX_PAGES),
      .PAGE_BYTES(PAGE_BYTES)
   ) u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_cmd            (req_cmd),
      .req_release_address(req_release_address),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_granted_address(rsp_granted_address),
      .rsp_status         (rsp_status),
      .rsp_free_pages     (rsp_free_pages),
      .rsp_managed_pages  (rsp_managed_pages),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // rebuild the managed range from the two registers
   function automatic void rebuild_range();
      logic [63:0] start_addr;
      logic [63:0] end_addr;
      logic [63:0] total;
      start_addr = ((64'(shadow_kend) + PAGE_BYTES - 1) / PAGE_BYTES) * PAGE_BYTES;
      if (start_addr < 64'(LOW_LIMIT)) begin
         start_addr = 64'(LOW_LIMIT);
      end
      end_addr = 64'(memory_end);
      if (end_addr > 64'(END_LIMIT)) begin
         end_addr = 64'(END_LIMIT);
      end
      total = (start_addr < end_addr) ? (end_addr - start_addr) / PAGE_BYTES : 64'd0;
      if (total > 64'(MAX_PAGES)) begin
         total = 64'(MAX_PAGES);
      end
      shadow_first  = 32'(start_addr / PAGE_BYTES);
      managed_count = int'(total);
      shadow_free   = managed_count;
      page_free     = '0;
      for (int unsigned i = 0; i < managed_count; i++) begin
         page_free[i] = 1'b1;
      end
      in_use_pages.delete();
   endfunction

   // first-fit allocate or release, updates the mirror
   function automatic page_result_type predict_page_op(logic cmd, logic [31:0] addr);
      page_result_type r;
      logic [31:0]     pg;
      logic [31:0]     page_addr;
      int unsigned     idx;
      r.granted = '0;
      r.status  = STAT_DONE;
      if (cmd == CMD_ALLOC) begin
         r.status = STAT_NO_MEMORY;
         for (int unsigned i = 0; i < managed_count; i++) begin
            if (page_free[i]) begin
               page_free[i] = 1'b0;
               shadow_free--;
               r.granted = 32'((64'(shadow_first) + i) * PAGE_BYTES);
               r.status  = STAT_DONE;
               in_use_pages.push_back(r.granted);
               break;
            end
         end
      end else begin
         pg = addr / PAGE_BYTES;
         if (pg < shadow_first || pg - shadow_first >= managed_count) begin
            r.status = STAT_RANGE;
         end else begin
            idx = pg - shadow_first;
            if (page_free[idx]) begin
               r.status = STAT_ALREADY_FREE;
            end else begin
               page_free[idx] = 1'b1;
               shadow_free++;
               page_addr = 32'((64'(shadow_first) + idx) * PAGE_BYTES);
               for (int k = 0; k < in_use_pages.size(); k++) begin
                  if (in_use_pages[k] == page_addr) begin
                     in_use_pages.delete(k);
                     break;
                  end
               end
            end
         end
      end
      r.free    = shadow_free[15:0];
      r.managed = managed_count[15:0];
      return r;
   endfunction

   // mostly short gaps, a few long ones
   function automatic int unsigned pick_gap();
      int unsigned roll;
      if (quiet_mode) begin
         return 0;
      end
      roll = $urandom_range(99);
      if (roll < 55) begin
         return 0;
      end
      if (roll < 85) begin
         return $urandom_range(3, 1);
      end
      if (roll < 96) begin
         return $urandom_range(8, 4);
      end
      return $urandom_range(60, 20);
   endfunction

   function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
         errors++;
      end
   endfunction

   function automatic plan_row_type item_row(logic cmd, logic [31:0] addr, int typed,
                                             logic [31:0] g, logic [1:0] s,
                                             int unsigned f, int unsigned m);
      plan_row_type r;
      r.kind     = ROW_ITEM;
      r.cmd      = cmd;
      r.reg_addr = '0;
      r.value    = addr;
      r.typed    = (typed != 0);
      r.want     = '{granted: g, status: s, free: 16'(f), managed: 16'(m)};
      return r;
   endfunction

   function automatic plan_row_type reg_row(logic [2:0] a, logic [31:0] v);
      plan_row_type r;
      r          = '0;
      r.kind     = ROW_REG;
      r.reg_addr = a;
      r.value    = v;
      return r;
   endfunction

   // present one beat and record its expected result at acceptance
   task automatic send_item(logic cmd, logic [31:0] addr, logic typed, page_result_type want);
      int unsigned     gap;
      page_result_type predicted;
      gap = holding ? 0 : pick_gap();
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid           <= 1'b1;
      req_cmd             <= cmd;
      req_release_address <= addr;
      do @(posedge clock); while (req_stall);
      predicted = predict_page_op(cmd, addr);
      awaited_results.push_back(typed ? want : predicted);
   endtask

   // drop valid and wait until every result is back
   task automatic quiesce();
      @(negedge clock);
      req_valid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // write a register, then read it back
   task automatic reg_write(logic [2:0] addr, logic [31:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (addr[2] == REG_KERNEL_END) begin
         shadow_kend = value;
      end else begin
         memory_end = value;
      end
      rebuild_range();
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      compare_field("register readback", value, csr_prdata);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // random beat: mostly allocs and releases of pages in use, some noise
   task automatic random_item(int unsigned alloc_pct);
      int unsigned roll;
      logic        cmd;
      logic [31:0] addr;
      logic [31:0] offset;
      addr   = $urandom();
      offset = $urandom_range(PAGE_BYTES - 1);
      cmd    = CMD_ALLOC;
      if ($urandom_range(99) >= alloc_pct) begin
         cmd  = CMD_RELEASE;
         roll = $urandom_range(99);
         if (roll < 60 && in_use_pages.size() != 0) begin
            addr = in_use_pages[$urandom_range(in_use_pages.size() - 1)] | offset;
         end else if (roll < 80 && managed_count != 0) begin
            addr = 32'((64'(shadow_first) + $urandom_range(managed_count - 1)) * PAGE_BYTES)
                   | offset;
         end else if (roll < 90) begin
            // just outside either end of the managed range
            addr = $urandom_range(1) ? shadow_first * PAGE_BYTES - 1
                                     : (shadow_first + managed_count) * PAGE_BYTES + offset;
         end
      end
      send_item(cmd, addr, 1'b0, '0);
   endtask

   task automatic run_phase(logic [31:0] kernel, logic [31:0] memory, int unsigned count,
                            int unsigned alloc_pct, bit hold, bit quiet);
      quiesce();
      reg_write(ADDR_KERNEL, kernel);
      reg_write(ADDR_MEMORY, memory);
      quiet_mode = quiet;
      if (hold) begin
         hold_off_req = 1'b1;
      end
      repeat (count) random_item(alloc_pct);
   endtask

   // receiver stalls, with a long hold-off on request that outlasts the clearing pass
   initial begin : rsp_side
      int unsigned span;
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            holding      = 1'b1;
            rsp_stall   <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            rsp_stall   <= 1'b0;
            holding      = 1'b0;
         end else begin
            span = pick_gap();
            if (span == 0) begin
               rsp_stall <= 1'b0;
            end else begin
               rsp_stall <= 1'b1;
               repeat (span) @(negedge clock);
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   // compare each result beat with the oldest expectation
   always @(posedge clock) begin
      page_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, got %h %0d %0d %0d", $time,
                     rsp_granted_address, rsp_status, rsp_free_pages, rsp_managed_pages);
            errors++;
         end else begin
            want = awaited_results.pop_front();
            compare_field("granted_address", want.granted, rsp_granted_address);
            compare_field("status", 32'(want.status), 32'(rsp_status));
            compare_field("free_pages", 32'(want.free), 32'(rsp_free_pages));
            compare_field("managed_pages", 32'(want.managed), 32'(rsp_managed_pages));
         end
      end
   end

   initial begin
      #(64'd25_000_000);
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      shadow_kend = KERNEL_END_RST;
      memory_end  = MEMORY_END_RST;
      rebuild_range();

      // default range: 32256 pages from 2 MB
      plan.push_back(item_row(CMD_ALLOC,   32'h0, 1, 32'h0020_0000, STAT_DONE, 32255, 32256));
      plan.push_back(item_row(CMD_ALLOC,   32'h0, 1, 32'h0020_1000, STAT_DONE, 32254, 32256));
      plan.push_back(item_row(CMD_RELEASE, 32'h0020_0000, 1, 0, STAT_DONE, 32255, 32256));
      // unaligned address inside a page that is already free
      plan.push_back(item_row(CMD_RELEASE, 32'h0020_0FFF, 1, 0, STAT_ALREADY_FREE, 32255, 32256));
      plan.push_back(item_row(CMD_RELEASE, 32'h0020_1ABC, 1, 0, STAT_DONE, 32256, 32256));
      plan.push_back(item_row(CMD_RELEASE, 32'h0000_0000, 1, 0, STAT_RANGE, 32256, 32256));
      plan.push_back(item_row(CMD_RELEASE, 32'hFFFF_FFFF, 1, 0, STAT_RANGE, 32256, 32256));
      plan.push_back(item_row(CMD_RELEASE, 32'h001F_FFFF, 1, 0, STAT_RANGE, 32256, 32256));
      plan.push_back(item_row(CMD_RELEASE, 32'h0800_0000, 1, 0, STAT_RANGE, 32256, 32256));
      plan.push_back(item_row(CMD_RELEASE, 32'h07FF_F000, 1, 0, STAT_ALREADY_FREE, 32256, 32256));
      plan.push_back(item_row(CMD_ALLOC,   32'hFFFF_FFFF, 1, 32'h0020_0000, STAT_DONE, 32255,
                              32256));
      plan.push_back(item_row(CMD_ALLOC,   32'h0, 0, 0, STAT_DONE, 0, 0));
      // kernel end rounds up past 32 bits
      plan.push_back(reg_row(ADDR_KERNEL, 32'hFFFF_F001));
      plan.push_back(item_row(CMD_ALLOC,   32'h0, 1, 0, STAT_NO_MEMORY, 0, 0));
      plan.push_back(item_row(CMD_RELEASE, 32'h0020_0000, 1, 0, STAT_RANGE, 0, 0));
      // start equal to end
      plan.push_back(reg_row(ADDR_KERNEL, 32'h0000_0000));
      plan.push_back(reg_row(ADDR_MEMORY, 32'h0020_0000));
      plan.push_back(item_row(CMD_ALLOC,   32'h0, 1, 0, STAT_NO_MEMORY, 0, 0));
      // capped at the full map
      plan.push_back(reg_row(ADDR_MEMORY, 32'hFFFF_FFFF));
      plan.push_back(item_row(CMD_ALLOC,   32'h0, 1, 32'h0020_0000, STAT_DONE, 32767, 32768));
      plan.push_back(item_row(CMD_RELEASE, 32'h081F_FFFF, 1, 0, STAT_ALREADY_FREE, 32767, 32768));
      plan.push_back(item_row(CMD_RELEASE, 32'h0820_0000, 1, 0, STAT_RANGE, 32767, 32768));
      // top of memory, end capped below 4 GB
      plan.push_back(reg_row(ADDR_KERNEL, 32'hFFFF_0000));
      plan.push_back(item_row(CMD_ALLOC,   32'h0, 1, 32'hFFFF_0000, STAT_DONE, 14, 15));
      plan.push_back(item_row(CMD_RELEASE, 32'hFFFF_FFFF, 1, 0, STAT_RANGE, 14, 15));
      plan.push_back(item_row(CMD_RELEASE, 32'hFFFF_E000, 1, 0, STAT_ALREADY_FREE, 14, 15));
      plan.push_back(item_row(CMD_RELEASE, 32'hFFFF_0010, 1, 0, STAT_DONE, 15, 15));
      // memory end below start
      plan.push_back(reg_row(ADDR_MEMORY, 32'h0000_0000));
      plan.push_back(item_row(CMD_ALLOC,   32'h0, 1, 0, STAT_NO_MEMORY, 0, 0));
      // unaligned kernel end, 63 pages
      plan.push_back(reg_row(ADDR_KERNEL, 32'h0040_0123));
      plan.push_back(reg_row(ADDR_MEMORY, 32'h0044_0000));
      plan.push_back(item_row(CMD_ALLOC,   32'h0, 0, 0, STAT_DONE, 0, 0));
      plan.push_back(item_row(CMD_RELEASE, 32'h0040_1000, 0, 0, STAT_DONE, 0, 0));

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed plan
      foreach (plan[n]) begin
         if (plan[n].kind == ROW_REG) begin
            quiesce();
            reg_write(plan[n].reg_addr, plan[n].value);
         end else begin
            send_item(plan[n].cmd, plan[n].value, plan[n].typed, plan[n].want);
         end
      end

      // random phases over several ranges
      run_phase(32'h0000_0000, 32'h0800_0000, 250, 50, 1, 0);
      run_phase(32'h0040_0123, 32'h0044_0000, 200, 60, 1, 0);
      run_phase(32'h7FFF_FFFF, 32'h8000_0000,  40, 50, 0, 1);
      run_phase(32'hFFFF_0000, 32'hFFFF_FFFF, 120, 55, 0, 0);
      run_phase(32'h0010_0000, 32'h0022_0000, 120, 55, 0, 1);
      run_phase(32'h0000_0000, 32'hFFFF_FFFF, 100, 70, 0, 0);
      run_phase(32'h0FFF_F001, 32'h1002_1FFF, 100, 55, 1, 0);

      quiesce();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire

// File: bitmap_page_allocator_core.f
hw/rtl/bpa_pkg.sv
hw/rtl/bpa_geom.sv
hw/rtl/bitmap_page_allocator_core.sv
hw/rtl/bpa_checker.sv
dv/tb_bitmap_page_allocator_core.sv
